// File: hdl/mkd_pkg.sv
// package for the matrix keypad debounce block: codes, widths and result type
`default_nettype none

package mkd_pkg;

   localparam int unsigned SNAPSHOT_BITS = 16;
   localparam int unsigned CODE_BITS     = 5;
   localparam int unsigned STAMP_BITS    = 32;
   localparam int unsigned INTERVAL_BITS = 8;
   localparam int unsigned DEBOUNCE_BITS = 10;
   localparam int unsigned CSR_DATA_BITS = 10;
   localparam int unsigned CSR_INDEX_BITS = 1;

   localparam logic [1:0] CMD_SCAN    = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCAN_INTERVAL = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE      = 1'd1;

   localparam logic [INTERVAL_BITS-1:0] SCAN_INTERVAL_RESET = 8'd10;
   localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET      = 10'd50;

   typedef struct packed {
      logic [CODE_BITS-1:0] debounced_key;
      logic                 key_matches;
      logic                 release_hit;
      logic                 press_flag;
      logic                 release_flag;
   } rsp_type;

endpackage

`default_nettype wire

// File: hdl/matrix_keypad_debounce.sv
// matrix keypad debounce: scan pacing, priority encode, debounce and event flags
//
// Requests arrive on the req_ channel (valid/stall) and each gives exactly one
// response on the rsp_ channel. A request is taken when req_valid is high and
// req_stall is low. The state update and the response are computed in the
// accepting cycle and registered in the response register (the skid stage if
// the receiver stalls); a request can be taken every cycle req_stall is low.
// The response register is backed by a one-entry skid stage: while the receiver
// stalls, one more request is still accepted into the skid stage, after which
// req_stall goes high until the response register drains. req_stall is a
// register output and does not depend on req_valid.
// The csr_ port writes scan_interval_ms (index 0) and debounce_ms (index 1)
// whenever csr_write is high; write it only while no request is in flight.
// Synchronous reset clears the timestamps, key codes and flags, empties both
// output stages and restores the interval to 10 ms and the debounce to 50 ms.
`default_nettype none

module matrix_keypad_debounce #(
   parameter int unsigned ROW_COUNT    = 4,
   parameter int unsigned COLUMN_COUNT = 4
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [1:0]                            req_command,
   input  wire  [mkd_pkg::STAMP_BITS-1:0]        req_now_ms,
   input  wire  [mkd_pkg::SNAPSHOT_BITS-1:0]     req_key_levels,
   input  wire  [mkd_pkg::CODE_BITS-1:0]         req_key_code,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [mkd_pkg::CODE_BITS-1:0]         rsp_debounced_key,
   output logic                                  rsp_key_matches,
   output logic                                  rsp_release_hit,
   output logic                                  rsp_press_flag,
   output logic                                  rsp_release_flag,
   input  wire                                   csr_write,
   input  wire  [mkd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire  [mkd_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import mkd_pkg::*;

   localparam int unsigned KeyCount = ROW_COUNT * COLUMN_COUNT;
   localparam int unsigned ScanKeys = (KeyCount < SNAPSHOT_BITS) ? KeyCount : SNAPSHOT_BITS;

   logic [INTERVAL_BITS-1:0] scan_interval_ff;
   logic [DEBOUNCE_BITS-1:0] debounce_ff;
   logic [STAMP_BITS-1:0]    last_scan_ff, last_scan_in;
   logic [STAMP_BITS-1:0]    last_change_ff, last_change_in;
   logic [CODE_BITS-1:0]     held_key_ff, held_key_in;
   logic [CODE_BITS-1:0]     previous_key_ff, previous_key_in;
   logic                     press_flag_ff, press_flag_in;
   logic                     release_flag_ff, release_flag_in;

   rsp_type                  out_ff, out_in, skid_ff, skid_in, result;
   logic                     out_valid_ff, out_valid_in;
   logic                     skid_valid_ff, skid_valid_in;

   logic                     accept;
   logic                     out_free;
   logic [STAMP_BITS-1:0]    scan_age;
   logic [STAMP_BITS-1:0]    change_age;
   logic                     scan_due;
   logic                     change_due;
   logic [CODE_BITS-1:0]     scan_code;
   logic                     hit;

   assign accept   = req_valid && !skid_valid_ff;
   assign out_free = !out_valid_ff || !rsp_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_interval_ff <= SCAN_INTERVAL_RESET;
         debounce_ff      <= DEBOUNCE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SCAN_INTERVAL: scan_interval_ff <= csr_wdata[INTERVAL_BITS-1:0];
            CSR_DEBOUNCE:      debounce_ff      <= csr_wdata[DEBOUNCE_BITS-1:0];
            default:           ;
         endcase
      end
   end

   // first pressed key in row-major order
   always_comb begin
      scan_code = '0;
      for (int i = ScanKeys - 1; i >= 0; i--) begin
         if (!req_key_levels[i]) begin
            scan_code = CODE_BITS'(i + 1);
         end
      end
   end

   assign scan_age   = req_now_ms - last_scan_ff;
   assign change_age = req_now_ms - last_change_ff;
   assign scan_due   = scan_age >= STAMP_BITS'(scan_interval_ff);
   assign change_due = change_age >= STAMP_BITS'(debounce_ff);

   always_comb begin
      last_scan_in    = last_scan_ff;
      last_change_in  = last_change_ff;
      held_key_in     = held_key_ff;
      previous_key_in = previous_key_ff;
      press_flag_in   = press_flag_ff;
      release_flag_in = release_flag_ff;
      hit             = 1'b0;
      case (req_command)
         CMD_SCAN: begin
            if (scan_due) begin
               last_scan_in = req_now_ms;
               if (scan_code != held_key_ff && change_due) begin
                  previous_key_in = held_key_ff;
                  held_key_in     = scan_code;
                  last_change_in  = req_now_ms;
                  if (held_key_ff != '0 && scan_code == '0) begin
                     release_flag_in = 1'b1;
                  end else if (held_key_ff == '0 && scan_code != '0) begin
                     press_flag_in = 1'b1;
                  end
               end
            end
         end
         CMD_RELEASE: begin
            if (release_flag_ff && previous_key_ff == req_key_code) begin
               release_flag_in = 1'b0;
               hit             = 1'b1;
            end
         end
         CMD_CLEAR: begin
            press_flag_in   = 1'b0;
            release_flag_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_comb begin
      result.debounced_key = held_key_in;
      result.key_matches   = (held_key_in == req_key_code);
      result.release_hit   = hit;
      result.press_flag    = press_flag_in;
      result.release_flag  = release_flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_scan_ff    <= '0;
         last_change_ff  <= '0;
         held_key_ff     <= '0;
         previous_key_ff <= '0;
         press_flag_ff   <= 1'b0;
         release_flag_ff <= 1'b0;
      end else if (accept) begin
         last_scan_ff    <= last_scan_in;
         last_change_ff  <= last_change_in;
         held_key_ff     <= held_key_in;
         previous_key_ff <= previous_key_in;
         press_flag_ff   <= press_flag_in;
         release_flag_ff <= release_flag_in;
      end
   end

   // response register with skid stage
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         out_valid_in  = skid_valid_ff || accept;
         out_in        = skid_valid_ff ? skid_ff : result;
         skid_valid_in = 1'b0;
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall         = skid_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign rsp_debounced_key = out_ff.debounced_key;
   assign rsp_key_matches   = out_ff.key_matches;
   assign rsp_release_hit   = out_ff.release_hit;
   assign rsp_press_flag    = out_ff.press_flag;
   assign rsp_release_flag  = out_ff.release_flag;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a response while the output stage is empty");

   a_hit_clears_flag: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.release_hit |-> !out_ff.release_flag)
      else $error("release hit reported with release flag still set");

   a_clear_flags: assert property (@(posedge clock) disable iff (reset)
      accept && req_command == CMD_CLEAR |=> !press_flag_ff && !release_flag_ff)
      else $error("clear request left a flag set");

   a_held_key_range: assert property (@(posedge clock) disable iff (reset)
      held_key_ff <= CODE_BITS'(ScanKeys))
      else $error("held key code out of range");

endmodule

`default_nettype wire
